>>> rtl/core/rbs_pkg.sv
`timescale 1ns / 1ps

package rbs_pkg;

    // configuration register indexes
    localparam int CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] CFG_BOX_MIN_X = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_BOX_MIN_Y = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_BOX_MIN_Z = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_BOX_MAX_X = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_BOX_MAX_Y = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_BOX_MAX_Z = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_MIN_HIT   = 3'd6;

    // reset value of the hit threshold
    localparam int MIN_HIT_RESET = 66;

    // side information that travels down the divider beside the remainder
    typedef struct packed {
        logic dzero;   // direction component is zero
        logic mzero;   // numerator is zero
        logic nneg;    // numerator is negative
        logic neg;     // quotient is negative
    } t_div_flags;

endpackage

>>> rtl/core/ray_box_slab_intersect.sv
`timescale 1ns / 1ps

// channel | dir | beat contents (lowest bits first)
// s       | in  | origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
// m       | out | hit, entry_distance
// cfg     | in  | register index, write data
//
// a ray enters every cycle unless the m side stalls; its result beat is offered once it has
// passed the divider, comparator and output registers
// the six dividers each compute one quotient bit per stage
// synchronous active-low reset clears the valid bits and the box registers
// a stall on the m side freezes the whole pipeline; nothing is dropped
module ray_box_slab_intersect #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_s_tvalid,
    output logic                                    o_s_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, zero pad
    input  logic [((6*COORD_WIDTH+7)/8)*8-1:0]      i_s_tdata,
    output logic                                    o_m_tvalid,
    input  logic                                    i_m_tready,
    // hit, entry_distance, zero pad
    output logic [((COORD_WIDTH+1+7)/8)*8-1:0]      o_m_tdata,
    input  logic                                    i_cfg_we,
    input  logic [rbs_pkg::CFG_ADDR_W-1:0]          i_cfg_addr,
    input  logic [COORD_WIDTH-1:0]                  i_cfg_wdata
);

    localparam int W        = COORD_WIDTH;
    localparam int OUT_BITS = ((W+1+7)/8)*8;
    localparam int PIPE_LAT = W + FRAC_BITS + 2 + 2;

    logic signed [W-1:0] r_box_lo [0:2];
    logic signed [W-1:0] r_box_hi [0:2];
    logic [W-2:0]        r_min_hit;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_box_lo[k] <= '0;
                r_box_hi[k] <= '0;
            end
            r_min_hit <= (W-1)'(rbs_pkg::MIN_HIT_RESET);
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                rbs_pkg::CFG_BOX_MIN_X: r_box_lo[0] <= i_cfg_wdata;
                rbs_pkg::CFG_BOX_MIN_Y: r_box_lo[1] <= i_cfg_wdata;
                rbs_pkg::CFG_BOX_MIN_Z: r_box_lo[2] <= i_cfg_wdata;
                rbs_pkg::CFG_BOX_MAX_X: r_box_hi[0] <= i_cfg_wdata;
                rbs_pkg::CFG_BOX_MAX_Y: r_box_hi[1] <= i_cfg_wdata;
                rbs_pkg::CFG_BOX_MAX_Z: r_box_hi[2] <= i_cfg_wdata;
                rbs_pkg::CFG_MIN_HIT:   r_min_hit   <= i_cfg_wdata[W-2:0];
                default: ;
            endcase
        end
    end

    // whole pipeline advances unless the output beat is held
    logic pipe_en;
    logic r_out_valid;
    assign pipe_en    = !r_out_valid || i_m_tready;
    assign o_s_tready = pipe_en;

    logic r_vld [0:PIPE_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < PIPE_LAT; k++)
                r_vld[k] <= 1'b0;
        end else if (pipe_en) begin
            r_vld[0] <= i_s_tvalid;
            for (int k = 1; k < PIPE_LAT; k++)
                r_vld[k] <= r_vld[k-1];
        end
    end

    logic signed [W-1:0] tin  [0:2];
    logic signed [W-1:0] tout [0:2];

    // entry and exit dividers per axis
    for (genvar a = 0; a < 3; a++) begin : g_axis
        rbs_div #(.COORD_WIDTH(W), .FRAC_BITS(FRAC_BITS), .IS_ENTRY(1'b1)) u_div_in (
            .i_clk    (i_clk),
            .i_en     (pipe_en),
            .i_lo     (r_box_lo[a]),
            .i_hi     (r_box_hi[a]),
            .i_origin (i_s_tdata[a*W +: W]),
            .i_dir    (i_s_tdata[(a+3)*W +: W]),
            .o_quot   (tin[a])
        );
        rbs_div #(.COORD_WIDTH(W), .FRAC_BITS(FRAC_BITS), .IS_ENTRY(1'b0)) u_div_out (
            .i_clk    (i_clk),
            .i_en     (pipe_en),
            .i_lo     (r_box_lo[a]),
            .i_hi     (r_box_hi[a]),
            .i_origin (i_s_tdata[a*W +: W]),
            .i_dir    (i_s_tdata[(a+3)*W +: W]),
            .o_quot   (tout[a])
        );
    end

    logic                cmp_ok;
    logic signed [W-1:0] cmp_tmin;

    rbs_cmp #(.COORD_WIDTH(W)) u_cmp (
        .i_clk   (i_clk),
        .i_en    (pipe_en),
        .i_txmin (tin[0]),
        .i_txmax (tout[0]),
        .i_tymin (tin[1]),
        .i_tymax (tout[1]),
        .i_tzmin (tin[2]),
        .i_tzmax (tout[2]),
        .o_ok    (cmp_ok),
        .o_tmin  (cmp_tmin)
    );

    // threshold test and output register
    logic          n_hit;
    logic [W-1:0]  n_entry;
    logic          r_hit;
    logic [W-1:0]  r_entry;

    always_comb begin
        n_hit   = cmp_ok && (cmp_tmin > $signed({1'b0, r_min_hit}));
        n_entry = n_hit ? cmp_tmin : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_out_valid <= 1'b0;
        else if (pipe_en)
            r_out_valid <= r_vld[PIPE_LAT-1];
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_hit   <= n_hit;
            r_entry <= n_entry;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_BITS'({r_entry, r_hit});

endmodule

>>> rtl/core/rbs_div.sv
`timescale 1ns / 1ps

// pipelined restoring divider for one slab distance, one quotient bit per stage
module rbs_div #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16,
    parameter bit IS_ENTRY    = 1'b1
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [COORD_WIDTH-1:0] i_lo,
    input  logic signed [COORD_WIDTH-1:0] i_hi,
    input  logic signed [COORD_WIDTH-1:0] i_origin,
    input  logic signed [COORD_WIDTH-1:0] i_dir,
    output logic signed [COORD_WIDTH-1:0] o_quot
);

    localparam int W  = COORD_WIDTH;
    localparam int QW = COORD_WIDTH + FRAC_BITS;

    logic [W-1:0]         r_rem [0:QW];
    logic [W-1:0]         r_num [0:QW];
    logic [W-1:0]         r_dv  [0:QW];
    logic [QW-1:0]        r_q   [0:QW];
    rbs_pkg::t_div_flags  r_fl  [0:QW];

    logic                 use_lo;
    logic [W-1:0]         bound;
    logic [W:0]           diff;
    logic [W-1:0]         n_mag;
    logic [W-1:0]         n_dm;
    rbs_pkg::t_div_flags  n_fl;

    // pick the slab plane, form the exact difference and the magnitudes
    always_comb begin
        use_lo     = i_dir[W-1] ? !IS_ENTRY : IS_ENTRY;
        bound      = use_lo ? i_lo : i_hi;
        diff       = {bound[W-1], bound} - {i_origin[W-1], i_origin};
        n_mag      = diff[W] ? W'(-diff) : diff[W-1:0];
        n_dm       = i_dir[W-1] ? W'(-i_dir) : i_dir;
        n_fl.dzero = (i_dir == '0);
        n_fl.mzero = (diff == '0);
        n_fl.nneg  = diff[W];
        n_fl.neg   = diff[W] ^ i_dir[W-1];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= '0;
            r_num[0] <= n_mag;
            r_dv[0]  <= n_dm;
            r_q[0]   <= '0;
            r_fl[0]  <= n_fl;
        end
    end

    // one quotient bit per stage; fraction bits shift in as zeros
    for (genvar g = 0; g < QW; g++) begin : g_step
        logic         bit_in;
        logic [W:0]   trial;
        logic         ge;
        logic [W:0]   n_rem;

        always_comb begin
            bit_in = (g < W) ? r_num[g][W-1] : 1'b0;
            trial  = {r_rem[g], bit_in};
            ge     = (trial >= {1'b0, r_dv[g]});
            n_rem  = ge ? trial - {1'b0, r_dv[g]} : trial;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g+1] <= n_rem[W-1:0];
                r_num[g+1] <= {r_num[g][W-2:0], 1'b0};
                r_dv[g+1]  <= r_dv[g];
                r_q[g+1]   <= {r_q[g][QW-2:0], ge};
                r_fl[g+1]  <= r_fl[g];
            end
        end
    end

    logic [QW-1:0]         lim;
    logic [QW-1:0]         qs;
    logic signed [W-1:0]   n_quot;

    // saturate, apply sign, then the zero-direction special cases
    always_comb begin
        lim = QW'({1'b0, {(W-1){1'b1}}}) + QW'(r_fl[QW].neg);
        qs  = (r_q[QW] > lim) ? lim : r_q[QW];
        n_quot = r_fl[QW].neg ? W'(-qs[W-1:0]) : qs[W-1:0];
        if (r_fl[QW].dzero) begin
            if (r_fl[QW].mzero)
                n_quot = IS_ENTRY ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
            else if (r_fl[QW].nneg)
                n_quot = {1'b1, {(W-2){1'b0}}, 1'b1};
            else
                n_quot = {1'b0, {(W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en)
            o_quot <= n_quot;
    end

endmodule

>>> rtl/core/rbs_cmp.sv
`timescale 1ns / 1ps

// interval merge: x against y, then z, two register stages
module rbs_cmp #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [COORD_WIDTH-1:0] i_txmin,
    input  logic signed [COORD_WIDTH-1:0] i_txmax,
    input  logic signed [COORD_WIDTH-1:0] i_tymin,
    input  logic signed [COORD_WIDTH-1:0] i_tymax,
    input  logic signed [COORD_WIDTH-1:0] i_tzmin,
    input  logic signed [COORD_WIDTH-1:0] i_tzmax,
    output logic                          o_ok,
    output logic signed [COORD_WIDTH-1:0] o_tmin
);

    logic                          r_ok1;
    logic signed [COORD_WIDTH-1:0] r_tmin1, r_tmax1, r_tzmin, r_tzmax;
    logic                          n_ok1, n_ok2;
    logic signed [COORD_WIDTH-1:0] n_tmin1, n_tmax1, n_tmin2;

    // x and y overlap and narrowing
    always_comb begin
        n_ok1   = !(i_txmin > i_tymax || i_tymin > i_txmax);
        n_tmin1 = (i_tymin > i_txmin) ? i_tymin : i_txmin;
        n_tmax1 = (i_tymax < i_txmax) ? i_tymax : i_txmax;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ok1   <= n_ok1;
            r_tmin1 <= n_tmin1;
            r_tmax1 <= n_tmax1;
            r_tzmin <= i_tzmin;
            r_tzmax <= i_tzmax;
        end
    end

    // z overlap and final entry
    always_comb begin
        n_ok2   = r_ok1 && !(r_tmin1 > r_tzmax || r_tzmin > r_tmax1);
        n_tmin2 = (r_tzmin > r_tmin1) ? r_tzmin : r_tmin1;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_ok   <= n_ok2;
            o_tmin <= n_tmin2;
        end
    end

endmodule

>>> tb/ray_box_slab_intersect_test.sv
`timescale 1ns / 1ps

module ray_box_slab_intersect_test;

    localparam int CW = 32;
    localparam int FB = 16;
    localparam int SW = ((6*CW+7)/8)*8;
    localparam int MW = ((CW+1+7)/8)*8;
    localparam int LATENCY = CW + FB + 5;
    localparam longint MAXV = 64'sd2147483647;
    localparam longint MINV = -64'sd2147483648;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic          hit;
        logic [CW-1:0] entry;
    } t_hit_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_s_tvalid = 1'b0;
    logic o_s_tready;
    logic [SW-1:0] i_s_tdata = '0;
    logic o_m_tvalid;
    logic i_m_tready = 1'b0;
    logic [MW-1:0] o_m_tdata;
    logic i_cfg_we = 1'b0;
    logic [rbs_pkg::CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [CW-1:0] i_cfg_wdata = '0;

    // local copy of the box registers
    logic signed [CW-1:0] box_lo [3];
    logic signed [CW-1:0] box_hi [3];
    logic [CW-2:0] hit_threshold;

    t_hit_result hit_queue [$];
    int error_count = 0;
    int cycle_count = 0;
    bit sink_idle_en = 1'b0;
    bit sink_hold = 1'b0;
    bit src_idle_en = 1'b0;

    ray_box_slab_intersect #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) DUT (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[ray_box_slab_intersect] ERROR");
            $finish;
        end
    end

    task automatic report(input string msg);
        $display("mismatch: %s", msg);
        error_count++;
    endtask

    // saturated fixed-point slab distance (bound - origin) * 2^FB / dir
    function automatic longint slab_distance(input longint bound, input longint origin,
                                             input longint dir, input bit is_entry);
        longint num;
        logic [127:0] mag_q, dm, quo;
        bit neg;
        num = bound - origin;
        if (dir == 0) begin
            if (num == 0) return is_entry ? MINV : MAXV;
            return (num < 0) ? -MAXV : MAXV;
        end
        if (num == 0) return 0;
        mag_q = (num < 0) ? -num : num;
        mag_q = mag_q << FB;
        dm = (dir < 0) ? -dir : dir;
        neg = (num < 0) != (dir < 0);
        quo = mag_q / dm;
        if (neg) begin
            if (quo > 128'd2147483648) quo = 128'd2147483648;
            return -longint'(quo[63:0]);
        end
        if (quo > 128'd2147483647) quo = 128'd2147483647;
        return longint'(quo[63:0]);
    endfunction

    function automatic t_hit_result predict_hit(input logic [6*CW-1:0] ray);
        longint tin [3];
        longint tout [3];
        longint o, d, tmin, tmax;
        t_hit_result r;
        for (int a = 0; a < 3; a++) begin
            o = longint'($signed(ray[a*CW +: CW]));
            d = longint'($signed(ray[(a+3)*CW +: CW]));
            if (d >= 0) begin
                tin[a] = slab_distance(box_lo[a], o, d, 1'b1);
                tout[a] = slab_distance(box_hi[a], o, d, 1'b0);
            end else begin
                tin[a] = slab_distance(box_hi[a], o, d, 1'b1);
                tout[a] = slab_distance(box_lo[a], o, d, 1'b0);
            end
        end
        r.hit = 1'b0;
        r.entry = '0;
        tmin = tin[0];
        tmax = tout[0];
        if (!(tmin > tout[1] || tin[1] > tmax)) begin
            if (tin[1] > tmin) tmin = tin[1];
            if (tout[1] < tmax) tmax = tout[1];
            if (!(tmin > tout[2] || tin[2] > tmax)) begin
                if (tin[2] > tmin) tmin = tin[2];
                if (tmin > longint'(hit_threshold)) begin
                    r.hit = 1'b1;
                    r.entry = tmin[CW-1:0];
                end
            end
        end
        return r;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_hit_result exp_r;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (hit_queue.size() == 0) begin
                report("result beat with nothing expected");
            end else begin
                exp_r = hit_queue.pop_front();
                if (o_m_tdata[0] !== exp_r.hit)
                    report($sformatf("hit got %b want %b", o_m_tdata[0], exp_r.hit));
                if (o_m_tdata[CW:1] !== exp_r.entry)
                    report($sformatf("entry got %h want %h", o_m_tdata[CW:1], exp_r.entry));
                if (o_m_tdata[MW-1:CW+1] !== '0)
                    report("pad bits not zero");
            end
        end
    end

    // receiver ready
    always @(posedge i_clk) begin
        if (sink_hold) i_m_tready <= 1'b0;
        else if (sink_idle_en) i_m_tready <= ($urandom_range(99) >= 18);
        else i_m_tready <= 1'b1;
    end

    // long receiver hold-off so the pipe fills and stalls the input
    task automatic hold_receiver(input int cycles);
        sink_hold = 1'b1;
        repeat (cycles) @(posedge i_clk);
        sink_hold = 1'b0;
    endtask

    // valid stays high after the beat is taken; drain drops it, and the next send only when it idles
    task automatic send_ray(input logic [6*CW-1:0] ray);
        while (src_idle_en && $urandom_range(99) < 18) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {{(SW-6*CW){1'b0}}, ray};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        hit_queue.push_back(predict_hit(ray));
    endtask

    // write enable stays high; set_box drops it after the last register
    task automatic write_reg(input logic [rbs_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [CW-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        case (idx)
            rbs_pkg::CFG_BOX_MIN_X: box_lo[0] = val;
            rbs_pkg::CFG_BOX_MIN_Y: box_lo[1] = val;
            rbs_pkg::CFG_BOX_MIN_Z: box_lo[2] = val;
            rbs_pkg::CFG_BOX_MAX_X: box_hi[0] = val;
            rbs_pkg::CFG_BOX_MAX_Y: box_hi[1] = val;
            rbs_pkg::CFG_BOX_MAX_Z: box_hi[2] = val;
            rbs_pkg::CFG_MIN_HIT:   hit_threshold = val[CW-2:0];
            default: ;
        endcase
    endtask

    task automatic drain;
        i_s_tvalid <= 1'b0;
        while (hit_queue.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic set_box(input logic [CW-1:0] lx, ly, lz, hx, hy, hz,
                           input logic [CW-1:0] thr);
        write_reg(rbs_pkg::CFG_BOX_MIN_X, lx);
        write_reg(rbs_pkg::CFG_BOX_MIN_Y, ly);
        write_reg(rbs_pkg::CFG_BOX_MIN_Z, lz);
        write_reg(rbs_pkg::CFG_BOX_MAX_X, hx);
        write_reg(rbs_pkg::CFG_BOX_MAX_Y, hy);
        write_reg(rbs_pkg::CFG_BOX_MAX_Z, hz);
        write_reg(rbs_pkg::CFG_MIN_HIT, thr);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [CW-1:0] fx(input int whole);
        return CW'(whole) << FB;
    endfunction

    function automatic logic [CW-1:0] rand_word;
        case ($urandom_range(5))
            0: return 32'h8000_0000 | $urandom_range(3);
            1: return 32'h7fff_ffff - $urandom_range(3);
            2: return CW'($urandom_range(6) - 3);
            3: return CW'($urandom);
            default: return CW'(int'($urandom_range(40 << FB)) - (20 << FB));
        endcase
    endfunction

    // ray with its origin near the box and a small random direction, with random words mixed in
    function automatic logic [6*CW-1:0] aimed_ray;
        logic [6*CW-1:0] r;
        for (int a = 0; a < 3; a++) begin
            r[a*CW +: CW] = CW'(int'($urandom_range(60 << FB)) - (30 << FB));
            case ($urandom_range(7))
                0: r[(a+3)*CW +: CW] = '0;
                1: r[(a+3)*CW +: CW] = rand_word();
                default: r[(a+3)*CW +: CW] = CW'(int'($urandom_range(4 << FB)) - (2 << FB));
            endcase
        end
        if ($urandom_range(3) == 0) r[$urandom_range(5)*CW +: CW] = rand_word();
        return r;
    endfunction

    task automatic test_reset_box;
        send_ray({fx(1), fx(1), fx(1), fx(-1), fx(-1), fx(-1)});
        send_ray('0);
        drain();
    endtask

    task automatic test_directed;
        set_box(fx(-2), fx(-2), fx(-2), fx(2), fx(2), fx(2), 32'd66);
        // axis aligned rays, both directions, and a diagonal ray
        send_ray({32'd0, 32'd0, fx(1), 32'd0, 32'd0, fx(-10)});
        send_ray({32'd0, fx(-1), 32'd0, 32'd0, fx(10), 32'd0});
        send_ray({fx(1), fx(1), fx(1), fx(-10), fx(-10), fx(-10)});
        // origin on a slab plane with zero direction
        send_ray({32'd0, 32'd0, fx(1), fx(-2), 32'd0, fx(-5)});
        // zero numerator with nonzero direction
        send_ray({fx(1), fx(1), fx(1), fx(-2), fx(-2), fx(-2)});
        // ray pointing away, miss
        send_ray({fx(1), fx(1), fx(1), fx(10), fx(10), fx(10)});
        // tiny direction, saturated quotient
        send_ray({32'd1, 32'd1, 32'd1, fx(-9), fx(-9), fx(-9)});
        send_ray({32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, fx(9), fx(9), fx(9)});
        // field extremes
        send_ray({32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff});
        send_ray({32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                  32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
        send_ray({6{32'hffff_ffff}});
        send_ray({6{32'h5555_5555}});
        send_ray({6{32'haaaa_aaaa}});
        drain();
        // extreme box and threshold
        set_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_ray({32'd1, 32'd1, 32'd1, 32'd0, 32'd0, 32'd0});
        send_ray({32'd1, 32'd1, 32'd1, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff});
        drain();
        set_box(fx(2), fx(2), fx(2), fx(-2), fx(-2), fx(-2), 32'd0);
        send_ray({32'd1, 32'd1, 32'd1, fx(-8), fx(-8), fx(-8)});
        send_ray({fx(-5), fx(-5), fx(-5), 32'd0, 32'd0, 32'd0});
        drain();
    endtask

    task automatic test_random(input int n, input bit idle);
        sink_idle_en = idle;
        src_idle_en = idle;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(9) < 8) send_ray(aimed_ray());
            else send_ray({CW'($urandom), CW'($urandom), CW'($urandom),
                           CW'($urandom), CW'($urandom), CW'($urandom)});
        end
        drain();
    endtask

    task automatic test_backpressure;
        fork
            hold_receiver(3 * LATENCY);
        join_none
        for (int i = 0; i < 2 * LATENCY; i++) send_ray(aimed_ray());
        drain();
    endtask

    initial begin
        box_lo = '{default: '0};
        box_hi = '{default: '0};
        hit_threshold = 66;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_box();
        test_directed();
        for (int ph = 0; ph < 5; ph++) begin
            set_box(CW'(-int'($urandom_range(8 << FB))), CW'(-int'($urandom_range(8 << FB))),
                    CW'(-int'($urandom_range(8 << FB))), CW'($urandom_range(8 << FB)),
                    CW'($urandom_range(8 << FB)), CW'($urandom_range(8 << FB)),
                    (ph == 0) ? 32'd0 : CW'($urandom_range(3 << FB)));
            test_random(250, ph != 1);
        end
        test_backpressure();
        if (error_count == 0) $display("[ray_box_slab_intersect] OK");
        else $display("[ray_box_slab_intersect] ERROR");
        $finish;
    end

endmodule

>>> ray_box_slab_intersect.f
rtl/core/rbs_pkg.sv
rtl/core/rbs_div.sv
rtl/core/rbs_cmp.sv
rtl/core/ray_box_slab_intersect.sv
tb/ray_box_slab_intersect_test.sv
